>>> rtl/tfidf_pkg.sv
// ----------------------------------------------------------------------------
// tfidf_pkg
// Shared types, constants and codes for the tf-idf weighting core.
// ----------------------------------------------------------------------------
package tfidf_pkg;

  localparam int unsigned DocCount   = 4096;
  localparam int unsigned DocW       = $clog2(DocCount);
  localparam int unsigned ValW       = 16;
  localparam int unsigned CfgW       = 13;
  localparam int unsigned ResW       = 32;
  localparam int unsigned IdfW       = 19;
  localparam int unsigned SumW       = 64;
  localparam int unsigned LogFracW   = 24;
  localparam int unsigned LogW       = 29;
  localparam logic [31:0] Log10Of2Q32 = 32'd1292913986;
  localparam logic [IdfW-1:0] IdfMax = {IdfW{1'b1}};
  localparam logic [CfgW-1:0] NumDocsReset = 13'd4096;

  typedef enum logic [1:0] {
    OP_LOAD_MAX = 2'd0,
    OP_TERM     = 2'd1,
    OP_POSTING  = 2'd2,
    OP_NORM     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_IDF    = 2'd0,
    KIND_WEIGHT = 2'd1,
    KIND_NORM   = 2'd2
  } kind_t;

  // Shared unit operations
  typedef enum logic [1:0] {
    FN_LOG2 = 2'd0,
    FN_DIV  = 2'd1,
    FN_SQRT = 2'd2
  } fn_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_LOGN,
    ST_LOGN_W,
    ST_LOGD,
    ST_LOGD_W,
    ST_SCALE,
    ST_IDFDONE,
    ST_MUL,
    ST_DIV_W,
    ST_SQ,
    ST_ACC,
    ST_SQRT_W,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic            start;
    fn_t             fn;
    logic [SumW-1:0] a;
    logic [31:0]     b;
  } unit_req_t;

  typedef struct packed {
    logic            done;
    logic [SumW-1:0] q;
  } unit_rsp_t;

endpackage

>>> rtl/tfidf_if.sv
// ----------------------------------------------------------------------------
// tfidf_if
// Valid/ready channel carrying a generic payload.
// ----------------------------------------------------------------------------
interface tfidf_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/tfidf_unit.sv
// ----------------------------------------------------------------------------
// tfidf_unit
// Shared iterative unit: log2 by repeated squaring, restoring division and
// bit-pair square root, one step per cycle.
// ----------------------------------------------------------------------------
module tfidf_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tfidf_pkg::unit_req_t req,
  output tfidf_pkg::unit_rsp_t rsp
);
  import tfidf_pkg::*;

  logic            busy_r, busy_nxt;
  fn_t             fn_r, fn_nxt;
  logic [5:0]      cnt_r, cnt_nxt;
  logic [SumW-1:0] a_r, a_nxt;     // log mantissa / radicand
  logic [SumW-1:0] q_r, q_nxt;     // result / dividend, then quotient
  logic [SumW-1:0] rem_r, rem_nxt; // remainder
  logic [31:0]     b_r, b_nxt;
  logic            done_r, done_nxt;

  logic [4:0]  lz;
  logic [63:0] sq;
  logic [33:0] trial;
  logic [65:0] rem_sh, sqt;

  always_comb begin
    lz = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (req.a[i]) lz = 5'(i);
    end
  end

  assign sq     = a_r[31:0] * a_r[31:0];
  assign rem_sh = {rem_r[63:0], a_r[63:62]};
  assign sqt    = {q_r[63:0], 2'b01};

  always_comb begin
    busy_nxt = busy_r;
    fn_nxt   = fn_r;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    b_nxt    = b_r;
    done_nxt = 1'b0;
    trial    = '0;
    if (req.start) begin
      busy_nxt = 1'b1;
      fn_nxt   = req.fn;
      b_nxt    = req.b;
      rem_nxt  = '0;
      unique case (req.fn)
        FN_LOG2: begin
          q_nxt   = SumW'(lz);
          a_nxt   = SumW'(req.a[31:0] << (5'd31 - lz));
          cnt_nxt = 6'(LogFracW);
        end
        FN_DIV: begin
          q_nxt   = req.a;
          a_nxt   = '0;
          cnt_nxt = 6'd40;
        end
        FN_SQRT: begin
          q_nxt   = '0;
          a_nxt   = req.a;
          cnt_nxt = 6'd32;
        end
        default: begin
          busy_nxt = 1'b0;
        end
      endcase
    end else if (busy_r) begin
      unique case (fn_r)
        FN_LOG2: begin
          // square mantissa; bit set when it reaches two
          if (sq[63]) begin
            q_nxt = {q_r[62:0], 1'b1};
            a_nxt = SumW'(sq[63:32]);
          end else begin
            q_nxt = {q_r[62:0], 1'b0};
            a_nxt = SumW'(sq[62:31]);
          end
        end
        FN_DIV: begin
          // dividend is at most 35 bits; shift 40 quotient bits
          trial = {rem_r[32:0], q_r[39]} - {2'b00, b_r};
          if (!trial[33]) begin
            rem_nxt = SumW'(trial[32:0]);
            q_nxt   = {q_r[62:0], 1'b1};
          end else begin
            rem_nxt = {rem_r[62:0], q_r[39]};
            q_nxt   = {q_r[62:0], 1'b0};
          end
        end
        FN_SQRT: begin
          a_nxt = {a_r[61:0], 2'b00};
          if (rem_sh >= sqt) begin
            rem_nxt = 64'(rem_sh - sqt);
            q_nxt   = {q_r[62:0], 1'b1};
          end else begin
            rem_nxt = rem_sh[63:0];
            q_nxt   = {q_r[62:0], 1'b0};
          end
        end
        default: begin
          busy_nxt = 1'b0;
        end
      endcase
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      fn_r   <= FN_LOG2;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      fn_r   <= fn_nxt;
    end
    a_r   <= a_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    b_r   <= b_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.q    = (fn_r == FN_DIV) ? {24'd0, q_r[39:0]} : q_r;

`ifndef ASSERT_OFF
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !req.start) else $error("unit restarted while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("done while busy");
  a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("done without work");
`endif

endmodule

>>> rtl/tfidf_weight_and_doc_norm_core.sv
// ----------------------------------------------------------------------------
// tfidf_weight_and_doc_norm_core
// tf-idf weighting with max-frequency normalisation and per-document norms.
// ----------------------------------------------------------------------------
// One request at a time passes through a sequencer that drives one shared
// iterative unit. A max-frequency load only writes its table entry; a term
// start runs two 24-step log2 runs (num_docs, then df), scaling and the
// result; a posting runs a 40-step division, squaring and the norm update;
// a norm read runs a 32-step square root. A zero df or zero num_docs skips
// both logs of a term start, and a zero max frequency skips the division
// and norm update of a posting, which then reports a divide error. No new
// request is taken before the sequencer is through with the last, and a
// result still waiting at the output holds the sequencer until it is taken.
// Norm sums live in a 4096-entry memory; after reset a clearing pass zeroes
// every entry before the first request is taken. Configuration writes are
// accepted at any time.
module tfidf_weight_and_doc_norm_core (
  input  logic clk,
  input  logic rst_n,
  tfidf_if.sink   in_ch,
  tfidf_if.source out_ch,
  tfidf_if.sink   cfg_ch
);
  import tfidf_pkg::*;

  state_t state_r, state_nxt;
  logic [CfgW-1:0] num_docs_r;
  logic [IdfW-1:0] idf_r;
  logic [1:0]      op_r;
  logic [DocW-1:0] doc_r;
  logic [ValW-1:0] val_r;
  logic [ValW-1:0] mf_r;
  logic [SumW-1:0] sum_r;
  logic [LogW-1:0] logn_r;
  logic [63:0]     prod_r;
  logic [IdfW-1:0] w_r;
  logic [63:0]     sq_r;
  logic            zero_r;

  logic            clr_r;
  logic [DocW:0]   clr_cnt_r;

  logic            ov_r;
  kind_t           ov_kind_r;
  logic [ResW-1:0] ov_val_r;
  logic            ov_err_r;

  logic [ValW-1:0] mf_mem [DocCount];
  logic [SumW-1:0] sum_mem[DocCount];

  unit_req_t ureq;
  unit_rsp_t ursp;

  logic            res_go;
  kind_t           res_kind;
  logic [ResW-1:0] res_val;
  logic            res_err;
  logic            sum_we;
  logic [DocW-1:0] sum_wa;
  logic [SumW-1:0] sum_wd;
  logic [64:0]     acc;

  tfidf_unit u_unit (.clk(clk), .rst_n(rst_n), .req(ureq), .rsp(ursp));

  assign in_ch.ready  = (state_r == ST_IDLE) && !clr_r;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = ov_r;
  assign out_ch.data.kind         = ov_kind_r;
  assign out_ch.data.result_value = ov_val_r;
  assign out_ch.data.divide_error = ov_err_r;

  assign acc  = {1'b0, sum_r} + {1'b0, sq_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid && in_ch.ready) state_nxt = ST_RD;
      end
      ST_RD: begin
        unique case (op_t'(op_r))
          OP_LOAD_MAX: state_nxt = ST_IDLE;
          OP_TERM:     state_nxt = ST_LOGN;
          OP_POSTING:  state_nxt = ST_MUL;
          OP_NORM:     state_nxt = ST_SQRT_W;
          default:     state_nxt = ST_IDLE;
        endcase
      end
      // skip both logs when df or num_docs is zero
      ST_LOGN:   state_nxt = zero_r ? ST_SCALE : ST_LOGN_W;
      ST_LOGN_W: if (ursp.done) state_nxt = ST_LOGD;
      ST_LOGD:   state_nxt = ST_LOGD_W;
      ST_LOGD_W: if (ursp.done) state_nxt = ST_SCALE;
      ST_SCALE:  state_nxt = ST_IDFDONE;
      ST_IDFDONE: if (!ov_r) state_nxt = ST_IDLE;
      ST_MUL:    state_nxt = zero_r ? ST_OUT : ST_DIV_W;
      ST_DIV_W:  if (ursp.done) state_nxt = ST_SQ;
      ST_SQ:     state_nxt = ST_ACC;
      ST_ACC:    if (!ov_r) state_nxt = ST_IDLE;
      ST_SQRT_W: if (ursp.done) state_nxt = ST_OUT;
      ST_OUT:    if (!ov_r) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    ureq     = '0;
    ureq.fn  = FN_LOG2;
    res_go   = 1'b0;
    res_kind = KIND_IDF;
    res_val  = '0;
    res_err  = 1'b0;
    sum_we   = 1'b0;
    sum_wa   = doc_r;
    sum_wd   = acc[64] ? {SumW{1'b1}} : acc[SumW-1:0];
    unique case (state_r)
      ST_RD: begin
        if (op_t'(op_r) == OP_NORM) begin
          ureq.start = 1'b1;
          ureq.fn    = FN_SQRT;
          ureq.a     = sum_r;
        end
      end
      ST_LOGN: begin
        ureq.start = !zero_r;
        ureq.a     = SumW'(num_docs_r);
      end
      ST_LOGD: begin
        ureq.start = !zero_r;
        ureq.a     = SumW'(val_r);
      end
      ST_MUL: begin
        if (!zero_r) begin
          ureq.start = 1'b1;
          ureq.fn    = FN_DIV;
          ureq.a     = prod_r;
          ureq.b     = 32'(mf_r);
        end
      end
      ST_IDFDONE: begin
        res_go  = !ov_r;
        res_val = ResW'(idf_r);
      end
      ST_ACC: begin
        res_go   = !ov_r;
        res_kind = KIND_WEIGHT;
        res_val  = ResW'(w_r);
        sum_we   = !ov_r;
      end
      ST_OUT: begin
        res_go = !ov_r;
        if (op_t'(op_r) == OP_NORM) begin
          res_kind = KIND_NORM;
          res_val  = ursp.q[31:0];
        end else begin
          res_kind = KIND_WEIGHT;
          res_err  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // memories; hold the read data once a request is taken
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_ch.valid && in_ch.ready &&
        op_t'(in_ch.data.op) == OP_LOAD_MAX) begin
      mf_mem[in_ch.data.doc_index] <= in_ch.data.value;
    end
    if (state_r == ST_IDLE) begin
      mf_r <= mf_mem[in_ch.data.doc_index];
    end
  end

  always_ff @(posedge clk) begin
    if (clr_r) begin
      sum_mem[clr_cnt_r[DocW-1:0]] <= '0;
    end else if (sum_we) begin
      sum_mem[sum_wa] <= sum_wd;
    end
    if (state_r == ST_IDLE) begin
      sum_r <= sum_mem[in_ch.data.doc_index];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      num_docs_r <= NumDocsReset;
      idf_r      <= '0;
      ov_r       <= 1'b0;
      clr_r      <= 1'b1;
      clr_cnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid && cfg_ch.ready) num_docs_r <= cfg_ch.data;
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == (DocW+1)'(DocCount - 1)) clr_r <= 1'b0;
      end
      if (res_go) ov_r <= 1'b1;
      else if (out_ch.valid && out_ch.ready) ov_r <= 1'b0;
      if (state_r == ST_SCALE) begin
        // drop negative logs; round half up and saturate
        if (zero_r || ursp.q[LogW-1:0] >= logn_r) begin
          idf_r <= '0;
        end else if (|prod_r[63:59]) begin
          idf_r <= IdfMax;
        end else begin
          idf_r <= 19'((prod_r[58:0] + 59'(64'd1 << 39)) >> 40);
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE) begin
      op_r  <= in_ch.data.op;
      doc_r <= in_ch.data.doc_index;
      val_r <= in_ch.data.value;
    end
    if (res_go) begin
      ov_kind_r <= res_kind;
      ov_val_r  <= res_val;
      ov_err_r  <= res_err;
    end
    unique case (state_r)
      ST_RD: begin
        zero_r <= (op_t'(op_r) == OP_TERM) ? (val_r == '0 || num_docs_r == '0)
                                           : (mf_r == '0);
        prod_r <= 64'(val_r) * 64'(idf_r);
      end
      ST_LOGN_W: if (ursp.done) logn_r <= ursp.q[LogW-1:0];
      ST_LOGD_W: if (ursp.done) begin
        // ursp.q holds log2(df); scale log2(num_docs) - log2(df)
        prod_r <= 64'(LogW'(logn_r - ursp.q[LogW-1:0])) * 64'(Log10Of2Q32);
        logn_r <= logn_r;
      end
      ST_DIV_W: if (ursp.done) begin
        w_r <= (|ursp.q[39:IdfW]) ? IdfMax : ursp.q[IdfW-1:0];
      end
      ST_SQ: sq_r <= 64'(w_r) * 64'(w_r);
      default: begin
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ch.ready) else $error("ready while busy");
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> (state_r == ST_IDLE)) else $error("request during clear");
  a_sum_we_ok: assert property (@(posedge clk) disable iff (!rst_n)
    sum_we |-> !clr_r) else $error("norm write during clear");
`endif

endmodule
